// ===== rtl/vpw_pkg.sv =====
package vpw_pkg;

    // Fixed-point format: signed 32-bit words with FRAC_BITS fraction bits
    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam logic [WORD_W-1:0] ONE_W   = 32'd1 << FRAC_BITS;
    localparam logic [WORD_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] S32_MIN = 32'h8000_0000;

    // Coefficient store: two 4x4 column-major matrices
    localparam int STORE_DEPTH = 32;
    localparam int IDX_W       = 5;
    localparam logic [IDX_W-1:0] MAC_LAST = 5'd31;

    // Row accumulator: four floor-shifted 64-bit products summed exactly
    localparam int ACC_W = 66 - FRAC_BITS;

    // Divider: |clip| scaled by 2^FRAC_BITS, one quotient bit per cycle
    localparam int LANES     = 3;
    localparam int NUM_W     = WORD_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    // Viewport mapping widths
    localparam int VP_OPND_W = WORD_W + 1;
    localparam int VP_PROD_W = VP_OPND_W + 17;
    localparam int VP_SUM_W  = VP_PROD_W + 1;

    // Input operation codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_VP_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VP_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VP_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VP_HEIGHT = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_NDC,
        ST_VP_MUL_X,
        ST_VP_ADD_X,
        ST_VP_MUL_Y,
        ST_VP_ADD_Y,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             coef_wr;
        logic             obj_ld;
        logic             mac_issue;
        logic [IDX_W-1:0] mac_step;
        logic             div_ld;
        logic             div_step;
        logic             ndc_ld;
        logic             vp_mul;
        logic             vp_add;
        logic             vp_sel;
        logic             out_ld;
    } cmd_t;

    typedef struct packed {
        logic w_zero;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/vpw_div.sv =====
module vpw_div (
    input  logic                                               clk,
    input  logic                                               ld,
    input  logic                                               step,
    input  logic [vpw_pkg::LANES-1:0][vpw_pkg::WORD_W-1:0]     dividend,
    input  logic [vpw_pkg::WORD_W-1:0]                         divisor,
    output logic [vpw_pkg::LANES-1:0][vpw_pkg::NUM_W-1:0]      quotient
);
    import vpw_pkg::*;

    logic [LANES-1:0][NUM_W-1:0]  num_reg;
    logic [LANES-1:0][NUM_W-1:0]  num_next;
    logic [LANES-1:0][WORD_W-1:0] rem_reg;
    logic [LANES-1:0][WORD_W-1:0] rem_next;
    logic [LANES-1:0][NUM_W-1:0]  quot_reg;
    logic [LANES-1:0][NUM_W-1:0]  quot_next;
    logic [WORD_W-1:0]            dvsr_reg;

    // One restoring step per lane: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        logic [WORD_W:0] trial;
        logic            fit;
        for (int l = 0; l < LANES; l++)
        begin
            trial        = {rem_reg[l], num_reg[l][NUM_W-1]};
            fit          = (trial >= {1'b0, dvsr_reg});
            rem_next[l]  = fit ? WORD_W'(trial - {1'b0, dvsr_reg}) : trial[WORD_W-1:0];
            num_next[l]  = {num_reg[l][NUM_W-2:0], 1'b0};
            quot_next[l] = {quot_reg[l][NUM_W-2:0], fit};
        end
    end

    // Load scaled magnitudes, then advance one bit per step
    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                num_reg[l]  <= {dividend[l], {FRAC_BITS{1'b0}}};
                rem_reg[l]  <= '0;
                quot_reg[l] <= '0;
            end
            dvsr_reg <= divisor;
        end
        else if (step)
        begin
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign quotient = quot_reg;

endmodule

// ===== rtl/vpw_ctrl.sv =====
module vpw_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             operation,
    output logic             in_stall,
    input  vpw_pkg::status_t status,
    output vpw_pkg::cmd_t    cmd
);
    import vpw_pkg::*;

    state_t               state_reg;
    state_t               state_next;
    logic [IDX_W-1:0]     step_reg;
    logic [IDX_W-1:0]     step_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_next;

    // Hold state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (in_valid && operation == OP_PROJECT)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == MAC_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                div_cnt_next = '0;
                state_next   = status.w_zero ? ST_FINISH : ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(NUM_W - 1))
                begin
                    state_next = ST_NDC;
                end
            end
            ST_NDC:      state_next = ST_VP_MUL_X;
            ST_VP_MUL_X: state_next = ST_VP_ADD_X;
            ST_VP_ADD_X: state_next = ST_VP_MUL_Y;
            ST_VP_MUL_Y: state_next = ST_VP_ADD_Y;
            ST_VP_ADD_Y: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.coef_wr = in_valid && operation == OP_LOAD;
                cmd.obj_ld  = in_valid && operation == OP_PROJECT;
            end
            ST_MAC:
            begin
                cmd.mac_issue = 1'b1;
                cmd.mac_step  = step_reg;
            end
            ST_DRAIN:    cmd.mac_step = step_reg;
            ST_DIV_LOAD: cmd.div_ld   = 1'b1;
            ST_DIV_RUN:  cmd.div_step = 1'b1;
            ST_NDC:      cmd.ndc_ld   = 1'b1;
            ST_VP_MUL_X: cmd.vp_mul   = 1'b1;
            ST_VP_ADD_X: cmd.vp_add   = 1'b1;
            ST_VP_MUL_Y:
            begin
                cmd.vp_mul = 1'b1;
                cmd.vp_sel = 1'b1;
            end
            ST_VP_ADD_Y:
            begin
                cmd.vp_add = 1'b1;
                cmd.vp_sel = 1'b1;
            end
            ST_FINISH:   cmd.out_ld   = status.out_free;
            default:     cmd          = '0;
        endcase
    end

    a_project_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && operation == OP_PROJECT)
        |=> (state_reg == ST_MAC && step_reg == '0))
        else $error("projection item did not start the multiply pass at step zero");

    a_mac_steps_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC && step_reg != MAC_LAST)
        |=> (state_reg == ST_MAC && step_reg == IDX_W'($past(step_reg) + 1'b1)))
        else $error("multiply pass skipped or left early");

    a_out_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_ld |-> status.out_free)
        else $error("result loaded over an untaken output item");

endmodule

// ===== rtl/vpw_dpath.sv =====
module vpw_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vpw_pkg::cmd_t                 cmd,
    output vpw_pkg::status_t              status,
    input  logic [vpw_pkg::IDX_W-1:0]     coef_index,
    input  logic signed [31:0]            coef_value,
    input  logic signed [31:0]            obj_x,
    input  logic signed [31:0]            obj_y,
    input  logic signed [31:0]            obj_z,
    input  logic signed [15:0]            vp_x,
    input  logic signed [15:0]            vp_y,
    input  logic [15:0]                   vp_width,
    input  logic [15:0]                   vp_height,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic signed [31:0]            win_x,
    output logic signed [31:0]            win_y,
    output logic signed [31:0]            win_z,
    output logic                          valid_res
);
    import vpw_pkg::*;

    localparam int SAT_W = (ACC_W > VP_SUM_W) ? ACC_W : VP_SUM_W;

    // Clamp a wide signed value to the 32-bit range
    function automatic logic [WORD_W-1:0] sat_wide(input logic signed [SAT_W-1:0] v);
        logic [WORD_W-1:0] r;
        if (&v[SAT_W-1:WORD_W-1] || ~|v[SAT_W-1:WORD_W-1])
            r = v[WORD_W-1:0];
        else if (v[SAT_W-1])
            r = S32_MIN;
        else
            r = S32_MAX;
        return r;
    endfunction

    // Apply the quotient sign and clamp to the 32-bit range
    function automatic logic [WORD_W-1:0] sat_quot(input logic [NUM_W-1:0] q, input logic neg);
        logic              hi;
        logic [WORD_W-1:0] r;
        hi = |q[NUM_W-1:WORD_W];
        if (neg)
            r = (hi || (q[WORD_W-1] && |q[WORD_W-2:0])) ? S32_MIN
                                                       : WORD_W'(~q[WORD_W-1:0] + 1'b1);
        else
            r = (hi || q[WORD_W-1]) ? S32_MAX : q[WORD_W-1:0];
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] mag32(input logic signed [WORD_W-1:0] v);
        return v[WORD_W-1] ? WORD_W'(~v + 1'b1) : v;
    endfunction

    function automatic logic is_diag(input logic [IDX_W-1:0] idx);
        return idx[3:2] == idx[1:0];
    endfunction

    logic signed [WORD_W-1:0]    coef_reg [STORE_DEPTH];
    logic signed [WORD_W-1:0]    obj_reg  [LANES];
    logic signed [WORD_W-1:0]    eye_reg  [4];
    logic signed [WORD_W-1:0]    clip_reg [4];

    logic signed [63:0]          mul_prod_reg;
    logic signed [63:0]          mul_prod_next;
    logic [IDX_W-1:0]            mul_step_reg;
    logic                        mul_vld_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_W-1:0]     acc_sum;
    logic signed [ACC_W-1:0]     prod_shifted;
    logic signed [WORD_W-1:0]    coef_sel;
    logic signed [WORD_W-1:0]    opnd_sel;
    logic                        mac_pass;
    logic [1:0]                  mac_row;
    logic [1:0]                  mac_col;
    logic [WORD_W-1:0]           row_sat;

    logic [LANES-1:0][WORD_W-1:0] div_dividend;
    logic [WORD_W-1:0]            div_divisor;
    logic [LANES-1:0][NUM_W-1:0]  div_quot;
    logic [LANES-1:0]             neg_reg;
    logic                         res_ok_reg;
    logic signed [WORD_W-1:0]     ndc_reg [LANES];

    logic signed [VP_OPND_W-1:0]  vp_opnd;
    logic signed [16:0]           vp_ext;
    logic signed [VP_PROD_W-1:0]  vp_prod_reg;
    logic signed [VP_PROD_W-1:0]  vp_half;
    logic signed [VP_SUM_W-1:0]   vp_org;
    logic signed [VP_SUM_W-1:0]   vp_sum;
    logic signed [VP_OPND_W-1:0]  z_sum;
    logic signed [WORD_W-1:0]     win_x_reg;
    logic signed [WORD_W-1:0]     win_y_reg;
    logic signed [WORD_W-1:0]     win_z_reg;

    logic                         out_valid_reg;
    logic signed [WORD_W-1:0]     out_x_reg;
    logic signed [WORD_W-1:0]     out_y_reg;
    logic signed [WORD_W-1:0]     out_z_reg;
    logic                         out_ok_reg;

    // Coefficient store, reset to two identity matrices
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                coef_reg[i] <= is_diag(IDX_W'(i)) ? ONE_W : '0;
            end
        end
        else if (cmd.coef_wr)
        begin
            coef_reg[coef_index] <= coef_value;
        end
    end

    // Latch the vertex
    always_ff @(posedge clk)
    begin
        if (cmd.obj_ld)
        begin
            obj_reg[0] <= obj_x;
            obj_reg[1] <= obj_y;
            obj_reg[2] <= obj_z;
        end
    end

    // Multiply stage: pick coefficient and operand for this step
    assign mac_pass = cmd.mac_step[4];
    assign mac_row  = cmd.mac_step[3:2];
    assign mac_col  = cmd.mac_step[1:0];
    assign coef_sel = coef_reg[{mac_pass, mac_col, mac_row}];

    always_comb
    begin
        opnd_sel = eye_reg[mac_col];
        if (!mac_pass)
        begin
            unique case (mac_col)
                2'd0:    opnd_sel = obj_reg[0];
                2'd1:    opnd_sel = obj_reg[1];
                2'd2:    opnd_sel = obj_reg[2];
                default: opnd_sel = ONE_W;
            endcase
        end
    end

    assign mul_prod_next = 64'(coef_sel) * 64'(opnd_sel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            mul_vld_reg <= cmd.mac_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac_issue)
        begin
            mul_prod_reg <= mul_prod_next;
            mul_step_reg <= cmd.mac_step;
        end
    end

    // Accumulate stage: floor-shift the product, sum the row, clamp at the last column
    assign prod_shifted = {{2{mul_prod_reg[63]}}, mul_prod_reg[63:FRAC_BITS]};
    assign acc_sum      = ((mul_step_reg[1:0] == 2'd0) ? '0 : acc_reg) + prod_shifted;
    assign row_sat      = sat_wide(SAT_W'(acc_sum));

    always_ff @(posedge clk)
    begin
        if (mul_vld_reg)
        begin
            acc_reg <= acc_sum;
            if (mul_step_reg[1:0] == 2'd3)
            begin
                if (mul_step_reg[4])
                    clip_reg[mul_step_reg[3:2]] <= row_sat;
                else
                    eye_reg[mul_step_reg[3:2]] <= row_sat;
            end
        end
    end

    assign status.w_zero = (clip_reg[3] == '0);

    // Divide clip x, y, z by clip w on magnitudes
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            div_dividend[l] = mag32(clip_reg[l]);
        end
    end
    assign div_divisor = mag32(clip_reg[3]);

    vpw_div u_div (
        .clk      (clk),
        .ld       (cmd.div_ld),
        .step     (cmd.div_step),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ok_reg <= 1'b0;
        end
        else if (cmd.div_ld)
        begin
            res_ok_reg <= !status.w_zero;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_ld)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                neg_reg[l] <= clip_reg[l][WORD_W-1] ^ clip_reg[3][WORD_W-1];
            end
        end
        if (cmd.ndc_ld)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                ndc_reg[l] <= sat_quot(div_quot[l], neg_reg[l]);
            end
        end
    end

    // Viewport: multiply (1 + ndc) by the extent, then halve and add the origin
    assign vp_opnd = (cmd.vp_sel ? VP_OPND_W'(ndc_reg[1]) : VP_OPND_W'(ndc_reg[0]))
                   + VP_OPND_W'(ONE_W);
    assign vp_ext  = {1'b0, (cmd.vp_sel ? vp_height : vp_width)};
    assign vp_half = vp_prod_reg >>> 1;
    assign vp_org  = VP_SUM_W'(cmd.vp_sel ? vp_y : vp_x) <<< FRAC_BITS;
    assign vp_sum  = vp_org + VP_SUM_W'(vp_half);
    // Depth stays inside the 32-bit range after halving
    assign z_sum   = VP_OPND_W'(ndc_reg[2]) + VP_OPND_W'(ONE_W);

    always_ff @(posedge clk)
    begin
        if (cmd.vp_mul)
        begin
            vp_prod_reg <= VP_PROD_W'(vp_opnd) * VP_PROD_W'(vp_ext);
        end
        if (cmd.vp_add)
        begin
            if (cmd.vp_sel)
            begin
                win_y_reg <= sat_wide(SAT_W'(vp_sum));
                win_z_reg <= z_sum[VP_OPND_W-1:1];
            end
            else
            begin
                win_x_reg <= sat_wide(SAT_W'(vp_sum));
            end
        end
    end

    // Output register: load when free, drop valid once taken
    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
        end
        else if (cmd.out_ld)
        begin
            out_valid_reg <= 1'b1;
            out_ok_reg    <= res_ok_reg;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            out_x_reg <= res_ok_reg ? win_x_reg : '0;
            out_y_reg <= res_ok_reg ? win_y_reg : '0;
            out_z_reg <= res_ok_reg ? win_z_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign win_x     = out_x_reg;
    assign win_y     = out_y_reg;
    assign win_z     = out_z_reg;
    assign valid_res = out_ok_reg;

    a_zero_w_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_ld && !res_ok_reg)
        |=> (out_valid && !valid_res && win_x == '0 && win_y == '0 && win_z == '0))
        else $error("failed projection did not return a zero result");

    a_mac_drained_before_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_ld |-> !mul_vld_reg)
        else $error("divider loaded while a row product was still in flight");

endmodule

// ===== rtl/vertex_project_to_window_top.sv =====
// Vertex projection to window coordinates (gluProject transform).
// Input channel (in_valid / in_stall): each item is a coefficient load or a
// vertex projection, selected by operation. A load writes one of 32 matrix
// coefficients (modelview 0-15, projection 16-31, column-major) and produces
// no result. A projection runs the vertex through both matrices on one shared
// multiply-accumulate unit (32 products, one per cycle), divides clip x, y, z by
// clip w on a three-lane restoring divider that retires one quotient bit per
// cycle, then maps through the viewport.
// Results are Q16.16. Zero clip w skips the divide and viewport; the next item
// is taken only once the result has been loaded into the output register.
// Output channel (out_valid / out_stall): one item per projection. A stalled
// result holds in the output register while the next projection is computed;
// that projection then waits in the block until the output register is taken.
// Configuration (cfg_valid / cfg_ready, always ready): viewport origin and size,
// which must be written only while the block is idle; the user is bound by this,
// as the block does not enforce it. Reset clears the viewport, loads both
// matrices with identity and empties the output register.
module vertex_project_to_window_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            operation,
    input  logic [4:0]                      coef_index,
    input  logic signed [31:0]              coef_value,
    input  logic signed [31:0]              obj_x,
    input  logic signed [31:0]              obj_y,
    input  logic signed [31:0]              obj_z,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [31:0]              win_x,
    output logic signed [31:0]              win_y,
    output logic signed [31:0]              win_z,
    output logic                            valid_res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vpw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                     cfg_data
);
    import vpw_pkg::*;

    logic signed [15:0] vp_x_reg;
    logic signed [15:0] vp_y_reg;
    logic [15:0]        vp_width_reg;
    logic [15:0]        vp_height_reg;
    cmd_t               cmd;
    status_t            status;

    assign cfg_ready = 1'b1;

    // Viewport registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_x_reg      <= '0;
            vp_y_reg      <= '0;
            vp_width_reg  <= '0;
            vp_height_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_VP_X:      vp_x_reg      <= cfg_data;
                REG_VP_Y:      vp_y_reg      <= cfg_data;
                REG_VP_WIDTH:  vp_width_reg  <= cfg_data;
                REG_VP_HEIGHT: vp_height_reg <= cfg_data;
                default:       vp_x_reg      <= vp_x_reg;
            endcase
        end
    end

    vpw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .status    (status),
        .cmd       (cmd)
    );

    vpw_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .obj_x      (obj_x),
        .obj_y      (obj_y),
        .obj_z      (obj_z),
        .vp_x       (vp_x_reg),
        .vp_y       (vp_y_reg),
        .vp_width   (vp_width_reg),
        .vp_height  (vp_height_reg),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .win_x      (win_x),
        .win_y      (win_y),
        .win_z      (win_z),
        .valid_res  (valid_res)
    );

endmodule

// ===== tb/tb_vertex_project_to_window_top.sv =====
`timescale 1ns / 100ps

module tb_vertex_project_to_window_top;

    import vpw_pkg::*;

    localparam longint UNIT     = longint'(1) <<< FRAC_BITS;
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;
    localparam int     SETTLE   = 100;
    localparam int     PROJ_SEL = 16;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               ok;
    } window_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic                    operation;
    logic [4:0]              coef_index;
    logic signed [31:0]      coef_value;
    logic signed [31:0]      obj_x;
    logic signed [31:0]      obj_y;
    logic signed [31:0]      obj_z;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [31:0]      win_x;
    logic signed [31:0]      win_y;
    logic signed [31:0]      win_z;
    logic                    valid_res;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [15:0]             cfg_data;

    // Predicted block state
    logic signed [31:0]      coef_store [STORE_DEPTH];
    longint                  vp_org_x;
    longint                  vp_org_y;
    longint                  vp_ext_w;
    longint                  vp_ext_h;
    window_t                 expected_windows [$];

    bit                      no_idle;
    int                      errors;
    int                      n_loads;
    int                      n_projections;
    int                      n_zero_w;
    int                      n_viewports;

    vertex_project_to_window_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .obj_x      (obj_x),
        .obj_y      (obj_y),
        .obj_z      (obj_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .win_x      (win_x),
        .win_y      (win_y),
        .win_z      (win_z),
        .valid_res  (valid_res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("vertex_project_to_window_top test failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX)
            return WORD_MAX;
        if (v < WORD_MIN)
            return WORD_MIN;
        return v;
    endfunction

    // One row of a column-major matrix times a 4-vector, floor-shifted products
    function automatic longint mat_row(input int base, input int r,
                                       input longint v0, input longint v1,
                                       input longint v2, input longint v3);
        longint vin [4];
        longint acc;
        longint coef;
        int     c;
        vin[0] = v0;
        vin[1] = v1;
        vin[2] = v2;
        vin[3] = v3;
        acc = 0;
        for (c = 0; c < 4; c++)
        begin
            coef = coef_store[base + c * 4 + r];
            acc += (coef * vin[c]) >>> FRAC_BITS;
        end
        return clamp_word(acc);
    endfunction

    function automatic longint to_ndc(input longint num, input longint w);
        return clamp_word((num * UNIT) / w);
    endfunction

    function automatic longint to_window(input longint origin, input longint extent,
                                         input longint ndc);
        return clamp_word(origin * UNIT + (((UNIT + ndc) * extent) >>> 1));
    endfunction

    function automatic window_t project_vertex(input logic signed [31:0] ox,
                                               input logic signed [31:0] oy,
                                               input logic signed [31:0] oz);
        longint  eye [4];
        longint  clip [4];
        window_t res;
        int      r;
        for (r = 0; r < 4; r++)
            eye[r] = mat_row(0, r, ox, oy, oz, UNIT);
        for (r = 0; r < 4; r++)
            clip[r] = mat_row(PROJ_SEL, r, eye[0], eye[1], eye[2], eye[3]);
        res = '0;
        if (clip[3] != 0)
        begin
            res.x  = 32'(to_window(vp_org_x, vp_ext_w, to_ndc(clip[0], clip[3])));
            res.y  = 32'(to_window(vp_org_y, vp_ext_h, to_ndc(clip[1], clip[3])));
            res.z  = 32'(clamp_word((UNIT + to_ndc(clip[2], clip[3])) >>> 1));
            res.ok = 1'b1;
        end
        return res;
    endfunction

    // Queue a predicted result behind the ones already waiting
    function automatic void append_expected(input window_t w);
        expected_windows.insert(expected_windows.size(), w);
    endfunction

    // ---------------------------------------------------------------
    // Random picks
    // ---------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'(UNIT);
            2:       return 32'(-UNIT);
            3, 4:    return $urandom;
            default: return $urandom_range(0, 32'h7FFFF) - 32'h40000;
        endcase
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 2))
                    0:       return 32'h0;
                    1:       return 32'h7FFF_FFFF;
                    default: return 32'h8000_0000;
                endcase
            end
            1, 2:    return $urandom;
            default: return $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Input channel
    // ---------------------------------------------------------------

    // Drive one item, hold it until taken, then update the prediction
    task automatic send_item(input logic op, input logic [4:0] idx, input logic [31:0] coef,
                             input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid   <= 1'b0;
            operation  <= 1'($urandom);
            coef_index <= 5'($urandom);
            coef_value <= $urandom;
            obj_x      <= $urandom;
            obj_y      <= $urandom;
            obj_z      <= $urandom;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        coef_index <= idx;
        coef_value <= coef;
        obj_x      <= x;
        obj_y      <= y;
        obj_z      <= z;
        do
            @(posedge clk);
        while (in_stall);
        if (op == OP_LOAD)
        begin
            coef_store[idx] = coef;
            n_loads++;
        end
        else
        begin
            append_expected(project_vertex(x, y, z));
            n_projections++;
            if (!expected_windows[$].ok)
                n_zero_w++;
        end
    endtask

    task automatic load_coef(input logic [4:0] idx, input logic [31:0] coef);
        send_item(OP_LOAD, idx, coef, $urandom, $urandom, $urandom);
    endtask

    task automatic project(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        send_item(OP_PROJECT, 5'($urandom), $urandom, x, y, z);
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Let every outstanding item finish, loads included
    task automatic wait_idle();
        release_input();
        while (expected_windows.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Configuration channel
    // ---------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_VP_X:      vp_org_x = $signed(data);
            REG_VP_Y:      vp_org_y = $signed(data);
            REG_VP_WIDTH:  vp_ext_w = longint'(data);
            REG_VP_HEIGHT: vp_ext_h = longint'(data);
            default:       ;
        endcase
    endtask

    task automatic set_viewport(input logic [15:0] x, input logic [15:0] y,
                                input logic [15:0] w, input logic [15:0] h);
        wait_idle();
        write_reg(REG_VP_X, x);
        write_reg(REG_VP_Y, y);
        write_reg(REG_VP_WIDTH, w);
        write_reg(REG_VP_HEIGHT, h);
        @(negedge clk);
        cfg_valid <= 1'b0;
        n_viewports++;
    endtask

    // ---------------------------------------------------------------
    // Output channel
    // ---------------------------------------------------------------

    // Stall the result side in bursts
    initial
    begin : drive_out_stall
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            n = pick_gap();
            if (n == 0)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    task automatic check_word(input string what, input logic [31:0] want_v,
                              input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            errors++;
            $display("%0t: %s expected %h, got %h", $time, what, want_v, got_v);
        end
    endtask

    // Compare each taken result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        window_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_windows.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h %h %h %b",
                         $time, win_x, win_y, win_z, valid_res);
            end
            else
            begin
                want = expected_windows.pop_front();
                check_word("win_x", want.x, win_x);
                check_word("win_y", want.y, win_y);
                check_word("win_z", want.z, win_z);
                check_word("valid_res", 32'(want.ok), 32'(valid_res));
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic reset_block();
        int k;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = OP_LOAD;
        coef_index = '0;
        coef_value = '0;
        obj_x      = '0;
        obj_y      = '0;
        obj_z      = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_VP_X;
        cfg_data   = '0;
        no_idle    = 1'b0;
        vp_org_x   = 0;
        vp_org_y   = 0;
        vp_ext_w   = 0;
        vp_ext_h   = 0;
        for (k = 0; k < STORE_DEPTH; k++)
            coef_store[k] = '0;
        for (k = 0; k < 4; k++)
        begin
            coef_store[k * 5]            = 32'(UNIT);
            coef_store[PROJ_SEL + k * 5] = 32'(UNIT);
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    endtask

    // Identity matrices and the zero viewport left by reset
    task automatic test_identity_default();
        project(32'h0, 32'h0, 32'h0);
        project(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        project(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    endtask

    // Viewport origin and size at their limits, window results saturate
    task automatic test_viewport_extremes();
        set_viewport(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
        project(32'h0000_8000, 32'hFFFF_8000, 32'h0);
        project(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        set_viewport(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
        project(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000);
    endtask

    // Modelview translation column
    task automatic test_translation();
        set_viewport(16'd0, 16'd0, 16'd640, 16'd480);
        load_coef(5'd12, 32'h0003_0000);
        load_coef(5'd13, 32'hFFFE_0000);
        project(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    endtask

    // Clip w taken from -z; z = 0 then leaves nothing to divide by
    task automatic test_perspective_divide();
        load_coef(5'd27, 32'hFFFF_0000);
        load_coef(5'd31, 32'h0);
        project(32'h0001_0000, 32'h0002_0000, 32'hFFFC_0000);
        project(32'h0000_8000, 32'h0000_8000, 32'h0);
    endtask

    // Coefficients at full scale push the eye vector into saturation
    task automatic test_coef_extremes();
        load_coef(5'd0, 32'h7FFF_FFFF);
        load_coef(5'd5, 32'h8000_0000);
        project(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_0000);
    endtask

    // Mostly whole-matrix or single-coefficient loads, interleaved with projections
    task automatic test_random_traffic(input int count);
        int         sent;
        int         k;
        int         base;
        bit         flat_w;
        logic [31:0] coef;
        sent = 0;
        while (sent < count)
        begin
            k = $urandom_range(0, 99);
            if (k < 8)
            begin
                base   = $urandom_range(0, 1) * PROJ_SEL;
                flat_w = (base == PROJ_SEL) && ($urandom_range(0, 3) == 0);
                for (k = 0; k < 16; k++)
                begin
                    coef = (flat_w && (k % 4 == 3)) ? 32'h0 : pick_coef();
                    load_coef(5'(base + k), coef);
                end
                sent += 16;
            end
            else if (k < 50)
            begin
                load_coef(5'($urandom), pick_coef());
                sent++;
            end
            else
            begin
                project(pick_coord(), pick_coord(), pick_coord());
                sent++;
            end
        end
    endtask

    initial
    begin
        errors        = 0;
        n_loads       = 0;
        n_projections = 0;
        n_zero_w      = 0;
        n_viewports   = 0;
        reset_block();
        test_identity_default();
        test_viewport_extremes();
        test_translation();
        test_perspective_divide();
        test_coef_extremes();

        set_viewport(16'd0, 16'd0, 16'd1920, 16'd1080);
        test_random_traffic(130);
        set_viewport(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        test_random_traffic(130);
        set_viewport(16'h8000, 16'h8000, 16'h0000, 16'h0000);
        test_random_traffic(130);
        set_viewport(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        test_random_traffic(130);
        set_viewport(16'hFF00, 16'd100, 16'd800, 16'd600);
        no_idle = 1'b1;
        test_random_traffic(130);
        no_idle = 1'b0;

        // Drain and let the tail settle
        release_input();
        while (expected_windows.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d coefficient loads and %0d projections (%0d with zero clip w)",
                 n_loads, n_projections, n_zero_w);
        $display("across %0d viewport settings, with random input gaps and output stalls",
                 n_viewports);
        if (errors == 0 && expected_windows.size() == 0)
            $display("vertex_project_to_window_top test passed");
        else
            $display("vertex_project_to_window_top test failed");
        $finish;
    end

endmodule
